>>> src/oss_pkg.sv
// ----------------------------------------------------------------------------
// oss_pkg
// Shared types and codes for the sorted multiset with rank lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package oss_pkg;

   // Request opcodes.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UPDATE,
      ST_SELECT
   } state_type;

   // Command broadcast from the sequencer to every cell of the chain.
   typedef struct packed {
      logic compare_en;
      logic update_en;
      logic op;
   } cell_cmd_type;

endpackage

`default_nettype wire

>>> src/oss_cell.sv
// ----------------------------------------------------------------------------
// oss_cell
// One slot of the sorted chain: holds a value, compares it with the request
// key and shifts in a neighbor's value or the key on an update.
// ----------------------------------------------------------------------------
`default_nettype none

module oss_cell #(
   parameter int VALUE_BITS = 31
) (
   input  wire                         clock,
   input  wire oss_pkg::cell_cmd_type  cmd,
   input  wire logic [VALUE_BITS-1:0]  key,
   input  wire logic                   found,
   input  wire logic                   occ,
   input  wire logic                   left_occ,
   input  wire logic                   left_gt,
   input  wire logic [VALUE_BITS-1:0]  left_val,
   input  wire logic [VALUE_BITS-1:0]  right_val,
   output logic      [VALUE_BITS-1:0]  val_out,
   output logic                        gt_out,
   output logic                        eq_out
);

   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  gt_ff, gt_in;
   logic                  eq_ff, eq_in;

   always_comb begin
      gt_in = gt_ff;
      eq_in = eq_ff;
      if (cmd.compare_en) begin
         gt_in = occ && (value_ff > key);
         eq_in = occ && (value_ff == key);
      end
   end

   always_comb begin
      value_in = value_ff;
      if (cmd.update_en) begin
         if (cmd.op == oss_pkg::OP_INSERT) begin
            // Everything above the key moves up one slot; the key lands in
            // the first slot that is greater than it or empty.
            if (left_gt) begin
               value_in = left_val;
            end else if (left_occ && (gt_ff || !occ)) begin
               value_in = key;
            end
         end else if (found && (gt_ff || eq_ff)) begin
            value_in = right_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      gt_ff    <= gt_in;
      eq_ff    <= eq_in;
   end

   assign val_out = value_ff;
   assign gt_out  = gt_ff;
   assign eq_out  = eq_ff;

endmodule

`default_nettype wire

>>> src/oss_chain.sv
// ----------------------------------------------------------------------------
// oss_chain
// Row of sorted cells with neighbor links, the hit flag for removes and the
// rank select for the answer.
// ----------------------------------------------------------------------------
`default_nettype none

module oss_chain #(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 31,
   parameter int CW         = $clog2(CAPACITY + 1),
   parameter int RW         = $clog2(CAPACITY)
) (
   input  wire                         clock,
   input  wire oss_pkg::cell_cmd_type  cmd,
   input  wire logic [VALUE_BITS-1:0]  key,
   input  wire logic [CW-1:0]          count,
   input  wire logic [RW-1:0]          rank,
   output logic                        found,
   output logic      [VALUE_BITS-1:0]  sel_val
);

   logic [VALUE_BITS-1:0] vals [CAPACITY];
   logic [CAPACITY-1:0]   gt_vec;
   logic [CAPACITY-1:0]   eq_vec;
   logic [CAPACITY-1:0]   occ_vec;

   // The compare flags are registered, so this is a plain OR of cell outputs.
   assign found   = |eq_vec;
   assign sel_val = vals[rank];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                  left_occ;
      logic                  left_gt;
      logic [VALUE_BITS-1:0] left_val;
      logic [VALUE_BITS-1:0] right_val;

      assign occ_vec[i] = count > CW'(i);

      if (i == 0) begin : g_first
         assign left_occ = 1'b1;
         assign left_gt  = 1'b0;
         assign left_val = key;
      end else begin : g_mid
         assign left_occ = occ_vec[i-1];
         assign left_gt  = gt_vec[i-1];
         assign left_val = vals[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_val = vals[i];
      end else begin : g_inner
         assign right_val = vals[i+1];
      end

      oss_cell #(
         .VALUE_BITS(VALUE_BITS)
      ) u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .key      (key),
         .found    (found),
         .occ      (occ_vec[i]),
         .left_occ (left_occ),
         .left_gt  (left_gt),
         .left_val (left_val),
         .right_val(right_val),
         .val_out  (vals[i]),
         .gt_out   (gt_vec[i]),
         .eq_out   (eq_vec[i])
      );
   end

endmodule

`default_nettype wire

>>> src/order_statistic_multiset.sv
// ----------------------------------------------------------------------------
// order_statistic_multiset
// Bounded sorted multiset with insert, remove and k-th smallest lookup.
// ----------------------------------------------------------------------------
// Each request passes through acceptance, a compare pass in which every
// cell of the chain checks its value against the request value, an update
// pass in which the cells shift one slot up (insert) or down (remove), and a
// rank select into the output register. The next request is taken once the
// select has loaded the output register; a result that is not taken holds
// the select stage. The store needs no clearing after reset, since only
// slots below the element count are read.
`default_nettype none

module order_statistic_multiset #(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 31
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_opcode,
   input  wire logic [VALUE_BITS-1:0]           req_value,
   input  wire logic [$clog2(CAPACITY)-1:0]     req_rank_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [VALUE_BITS-1:0]           rsp_kth_value,
   output logic                                 rsp_kth_valid,
   output logic                                 rsp_insert_dropped,
   output logic      [$clog2(CAPACITY+1)-1:0]   rsp_element_count
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int RW = $clog2(CAPACITY);

   oss_pkg::state_type    state_ff, state_in;
   oss_pkg::cell_cmd_type cmd;

   logic [CW-1:0]         count_ff, count_in;
   logic                  op_ff, op_in;
   logic [VALUE_BITS-1:0] key_ff, key_in;
   logic [RW-1:0]         rank_ff, rank_in;
   logic                  drop_ff, drop_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] kth_value_ff, kth_value_in;
   logic                  kth_valid_ff, kth_valid_in;
   logic                  dropped_ff, dropped_in;
   logic [CW-1:0]         elem_count_ff, elem_count_in;

   logic                  found;
   logic [VALUE_BITS-1:0] sel_val;
   logic                  full;
   logic                  accept;
   logic                  out_free;

   assign full     = (count_ff == CW'(CAPACITY));
   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   oss_chain #(
      .CAPACITY  (CAPACITY),
      .VALUE_BITS(VALUE_BITS),
      .CW        (CW),
      .RW        (RW)
   ) u_chain (
      .clock  (clock),
      .cmd    (cmd),
      .key    (key_ff),
      .count  (count_ff),
      .rank   (rank_ff),
      .found  (found),
      .sel_val(sel_val)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         oss_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = oss_pkg::ST_COMPARE;
            end
         end
         oss_pkg::ST_COMPARE: state_in = oss_pkg::ST_UPDATE;
         oss_pkg::ST_UPDATE:  state_in = oss_pkg::ST_SELECT;
         oss_pkg::ST_SELECT: begin
            if (out_free) begin
               state_in = oss_pkg::ST_IDLE;
            end
         end
         default: state_in = oss_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready      = 1'b0;
      cmd.compare_en = 1'b0;
      cmd.update_en  = 1'b0;
      cmd.op         = op_ff;
      unique case (state_ff)
         oss_pkg::ST_IDLE:    req_ready      = 1'b1;
         oss_pkg::ST_COMPARE: cmd.compare_en = 1'b1;
         oss_pkg::ST_UPDATE:  cmd.update_en  = !((op_ff == oss_pkg::OP_INSERT) && full);
         oss_pkg::ST_SELECT:  ;
         default:             ;
      endcase
   end

   // Request capture and element count.
   always_comb begin
      op_in    = op_ff;
      key_in   = key_ff;
      rank_in  = rank_ff;
      drop_in  = drop_ff;
      count_in = count_ff;
      if (accept) begin
         op_in   = req_opcode;
         key_in  = req_value;
         rank_in = req_rank_index;
      end
      if (state_ff == oss_pkg::ST_UPDATE) begin
         drop_in = (op_ff == oss_pkg::OP_INSERT) && full;
         if (op_ff == oss_pkg::OP_INSERT) begin
            if (!full) begin
               count_in = count_ff + CW'(1);
            end
         end else if (found) begin
            count_in = count_ff - CW'(1);
         end
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      kth_value_in  = kth_value_ff;
      kth_valid_in  = kth_valid_ff;
      dropped_in    = dropped_ff;
      elem_count_in = elem_count_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == oss_pkg::ST_SELECT) && out_free) begin
         rsp_valid_in  = 1'b1;
         kth_valid_in  = CW'(rank_ff) < count_ff;
         kth_value_in  = (CW'(rank_ff) < count_ff) ? sel_val : '0;
         dropped_in    = drop_ff;
         elem_count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= oss_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      rank_ff       <= rank_in;
      drop_ff       <= drop_in;
      kth_value_ff  <= kth_value_in;
      kth_valid_ff  <= kth_valid_in;
      dropped_ff    <= dropped_in;
      elem_count_ff <= elem_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kth_value      = kth_value_ff;
   assign rsp_kth_valid      = kth_valid_ff;
   assign rsp_insert_dropped = dropped_ff;
   assign rsp_element_count  = elem_count_ff;

endmodule

`default_nettype wire

>>> src/oss_checker.sv
// ----------------------------------------------------------------------------
// oss_checker
// Port-level checks for the sorted multiset, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module oss_checker #(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 31
) (
   input wire                                 clock,
   input wire                                 reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           req_opcode,
   input wire logic [VALUE_BITS-1:0]          req_value,
   input wire logic [$clog2(CAPACITY)-1:0]    req_rank_index,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [VALUE_BITS-1:0]          rsp_kth_value,
   input wire logic                           rsp_kth_valid,
   input wire logic                           rsp_insert_dropped,
   input wire logic [$clog2(CAPACITY+1)-1:0]  rsp_element_count
);

   localparam int CW = $clog2(CAPACITY + 1);

   // A waiting request keeps its payload until it is taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_opcode)
         && $stable(req_value) && $stable(req_rank_index))
      else $error("request changed while waiting");

   // A stalled response keeps its k-th value and element count.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kth_value)
         && $stable(rsp_element_count))
      else $error("response changed while stalled");

   // A rank at or beyond the count answers zero.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kth_valid |-> rsp_kth_value == '0)
      else $error("invalid rank returned a nonzero value");

   // An insert is only dropped when the store is full.
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_insert_dropped |-> rsp_element_count == CW'(CAPACITY))
      else $error("insert dropped below capacity");

   // A valid rank needs at least one stored value, and the count stays bounded.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_element_count <= CW'(CAPACITY)
         && (!rsp_kth_valid || rsp_element_count != '0))
      else $error("element count out of range");

endmodule

bind order_statistic_multiset oss_checker #(
   .CAPACITY  (CAPACITY),
   .VALUE_BITS(VALUE_BITS)
) u_oss_checker (.*);

`default_nettype wire
